// File: rtl/hnpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed name permit list package
// Shared constants, control word layout, microcode program and hash helpers.
// ----------------------------------------------------------------------------
package hnpl_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int HASH_W      = 32;
  localparam int NUM_BUILTIN = 7;
  localparam int BI_W        = $clog2(NUM_BUILTIN);
  localparam int STR_BYTES   = 24;

  localparam logic [HASH_W-1:0] HASH_MUL = 32'h5bd1e995;

  localparam logic [1:0] CMD_CHECK  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam int OP_W   = 4;
  localparam int SEQ_W  = 3;
  localparam int COND_W = 4;
  localparam int PC_W   = 4;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_BYTE_A   = 4'd1;
  localparam op_t OP_BYTE_B   = 4'd2;
  localparam op_t OP_FIN_A    = 4'd3;
  localparam op_t OP_FIN_B    = 4'd4;
  localparam op_t OP_READ     = 4'd5;
  localparam op_t OP_CHK_CMP  = 4'd6;
  localparam op_t OP_SET_ZERO = 4'd7;
  localparam op_t OP_ADD_CMP  = 4'd8;
  localparam op_t OP_REM_CMP  = 4'd9;
  localparam op_t OP_FILL     = 4'd10;

  localparam logic [SEQ_W-1:0] SEQ_NEXT           = 3'd0;
  localparam logic [SEQ_W-1:0] SEQ_JUMP           = 3'd1;
  localparam logic [SEQ_W-1:0] SEQ_END            = 3'd2;
  localparam logic [SEQ_W-1:0] SEQ_DONE           = 3'd3;
  localparam logic [SEQ_W-1:0] SEQ_DONE_ELSE_JUMP = 3'd4;

  localparam logic [COND_W-1:0] C_ALWAYS     = 4'd0;
  localparam logic [COND_W-1:0] C_BYTE_ZERO  = 4'd1;
  localparam logic [COND_W-1:0] C_NOT_LAST   = 4'd2;
  localparam logic [COND_W-1:0] C_CMD_CHECK  = 4'd3;
  localparam logic [COND_W-1:0] C_CMD_ADD    = 4'd4;
  localparam logic [COND_W-1:0] C_CMD_REMOVE = 4'd5;
  localparam logic [COND_W-1:0] C_HASH_ZERO  = 4'd6;
  localparam logic [COND_W-1:0] C_SCAN_STOP  = 4'd7;
  localparam logic [COND_W-1:0] C_I_NOT_LAST = 4'd8;
  localparam logic [COND_W-1:0] C_W_END      = 4'd9;

  localparam logic [PC_W-1:0] L_BYTE_A = 4'd0;
  localparam logic [PC_W-1:0] L_FIN_A  = 4'd2;
  localparam logic [PC_W-1:0] L_CHK    = 4'd7;
  localparam logic [PC_W-1:0] L_ADD    = 4'd9;
  localparam logic [PC_W-1:0] L_ADD_RD = 4'd10;
  localparam logic [PC_W-1:0] L_REM    = 4'd12;
  localparam logic [PC_W-1:0] L_FILL   = 4'd14;

  typedef struct packed {
    op_t               op;
    logic [SEQ_W-1:0]  seq;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } cw_t;

  typedef struct packed {
    logic scan_stop;
    logic i_not_last;
    logic w_end;
  } tbl_flags_t;

  typedef struct packed {
    logic       byte_zero;
    logic       not_last;
    logic       cmd_check;
    logic       cmd_add;
    logic       cmd_remove;
    logic       hash_zero;
    tbl_flags_t tbl;
  } flags_t;

  function automatic cw_t ucode_rom(input logic [PC_W-1:0] a);
    cw_t w;
    unique case (a)
      4'd0:    w = '{op: OP_BYTE_A,   seq: SEQ_JUMP,           cond: C_BYTE_ZERO,  target: L_FIN_A};
      4'd1:    w = '{op: OP_BYTE_B,   seq: SEQ_END,            cond: C_NOT_LAST,   target: L_BYTE_A};
      4'd2:    w = '{op: OP_FIN_A,    seq: SEQ_NEXT,           cond: C_ALWAYS,     target: L_BYTE_A};
      4'd3:    w = '{op: OP_FIN_B,    seq: SEQ_JUMP,           cond: C_CMD_ADD,    target: L_ADD};
      4'd4:    w = '{op: OP_NONE,     seq: SEQ_JUMP,           cond: C_CMD_REMOVE, target: L_REM};
      4'd5:    w = '{op: OP_NONE,     seq: SEQ_JUMP,           cond: C_CMD_CHECK,  target: L_CHK};
      4'd6:    w = '{op: OP_NONE,     seq: SEQ_DONE,           cond: C_ALWAYS,     target: L_BYTE_A};
      4'd7:    w = '{op: OP_READ,     seq: SEQ_NEXT,           cond: C_ALWAYS,     target: L_BYTE_A};
      4'd8:    w = '{op: OP_CHK_CMP,  seq: SEQ_DONE_ELSE_JUMP, cond: C_SCAN_STOP,  target: L_CHK};
      4'd9:    w = '{op: OP_SET_ZERO, seq: SEQ_DONE,           cond: C_HASH_ZERO,  target: L_BYTE_A};
      4'd10:   w = '{op: OP_READ,     seq: SEQ_NEXT,           cond: C_ALWAYS,     target: L_BYTE_A};
      4'd11:   w = '{op: OP_ADD_CMP,  seq: SEQ_DONE_ELSE_JUMP, cond: C_SCAN_STOP,  target: L_ADD_RD};
      4'd12:   w = '{op: OP_READ,     seq: SEQ_NEXT,           cond: C_ALWAYS,     target: L_BYTE_A};
      4'd13:   w = '{op: OP_REM_CMP,  seq: SEQ_JUMP,           cond: C_I_NOT_LAST, target: L_REM};
      4'd14:   w = '{op: OP_FILL,     seq: SEQ_DONE_ELSE_JUMP, cond: C_W_END,      target: L_FILL};
      default: w = '{op: OP_NONE,     seq: SEQ_DONE,           cond: C_ALWAYS,     target: L_BYTE_A};
    endcase
    return w;
  endfunction

  function automatic logic [HASH_W-1:0] mul_m(input logic [HASH_W-1:0] a);
    logic [HASH_W-1:0] p;
    p = a * HASH_MUL;
    return p;
  endfunction

  function automatic logic [HASH_W-1:0] mix24(input logic [HASH_W-1:0] a);
    return a ^ (a >> 24);
  endfunction

  function automatic logic [HASH_W-1:0] mix13(input logic [HASH_W-1:0] a);
    return a ^ (a >> 13);
  endfunction

  function automatic logic [HASH_W-1:0] mix15(input logic [HASH_W-1:0] a);
    return a ^ (a >> 15);
  endfunction

  function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    logic [HASH_W-1:0] v;
    v = mul_m({24'd0, b});
    v = mul_m(mix24(v));
    return mul_m(h) ^ v;
  endfunction

  // The text is right-justified in s, so its first character sits highest.
  function automatic logic [HASH_W-1:0] hash_string(input logic [8*STR_BYTES-1:0] s,
                                                    input int n);
    logic [HASH_W-1:0] h;
    h = '0;
    for (int k = 0; k < n; k++) begin
      h = fold_byte(h, s[8*(n-1-k) +: 8]);
    end
    return mix15(mul_m(mix13(h)));
  endfunction

  localparam logic [HASH_W-1:0] BUILTIN_HASH [NUM_BUILTIN] = '{
    hash_string({"PASE", "Session"}, 11),
    hash_string({"CASE", "Session"}, 11),
    hash_string("NetworkCommissioning", 20),
    hash_string("GeneralCommissioning", 20),
    hash_string("OperationalCredentials", 22),
    hash_string({"CASE", "Server"}, 10),
    hash_string("Fabric", 6)
  };

endpackage

// File: rtl/hnpl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed name permit list sequencer
// Step counter over the microcode ROM with conditional jumps and ends.
// ----------------------------------------------------------------------------
module hnpl_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  hnpl_pkg::flags_t flags,
  output logic            busy,
  output logic            done,
  output hnpl_pkg::op_t   op
);
  import hnpl_pkg::*;

  logic            run;
  logic            run_next;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  cw_t             cw;
  logic            cond_true;
  logic            ending;
  logic            emit;
  logic            accept;

  always_comb cw = ucode_rom(pc);

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:     cond_true = 1'b1;
      C_BYTE_ZERO:  cond_true = flags.byte_zero;
      C_NOT_LAST:   cond_true = flags.not_last;
      C_CMD_CHECK:  cond_true = flags.cmd_check;
      C_CMD_ADD:    cond_true = flags.cmd_add;
      C_CMD_REMOVE: cond_true = flags.cmd_remove;
      C_HASH_ZERO:  cond_true = flags.hash_zero;
      C_SCAN_STOP:  cond_true = flags.tbl.scan_stop;
      C_I_NOT_LAST: cond_true = flags.tbl.i_not_last;
      C_W_END:      cond_true = flags.tbl.w_end;
      default:      cond_true = 1'b0;
    endcase
  end

  always_comb begin
    ending  = 1'b0;
    emit    = 1'b0;
    pc_next = pc + 1'b1;
    unique case (cw.seq)
      SEQ_NEXT: begin
        pc_next = pc + 1'b1;
      end
      SEQ_JUMP: begin
        if (cond_true) begin
          pc_next = cw.target;
        end
      end
      SEQ_END: begin
        ending = cond_true;
      end
      SEQ_DONE: begin
        ending = cond_true;
        emit   = cond_true;
      end
      SEQ_DONE_ELSE_JUMP: begin
        ending = cond_true;
        emit   = cond_true;
        if (!cond_true) begin
          pc_next = cw.target;
        end
      end
      default: begin
        ending = 1'b1;
      end
    endcase
  end

  assign busy   = run && !ending;
  assign accept = start && !busy;
  assign op     = run ? cw.op : OP_NONE;

  always_comb begin
    if (accept) begin
      run_next = 1'b1;
    end else if (run && ending) begin
      run_next = 1'b0;
    end else begin
      run_next = run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      pc   <= '0;
      done <= 1'b0;
    end else begin
      run  <= run_next;
      done <= run && emit;
      if (accept) begin
        pc <= L_BYTE_A;
      end else if (run) begin
        pc <= pc_next;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (run && pc == L_BYTE_A))
    else $error("Accepted transfer did not restart the program.");

  a_done_from_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run))
    else $error("Result strobe without a running program.");

endmodule

// File: rtl/hnpl_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed name permit list hash datapath
// Running bytewise hash and final mix on two constant multipliers.
// ----------------------------------------------------------------------------
module hnpl_hash (
  input  logic                          clk,
  input  logic                          rst,
  input  hnpl_pkg::op_t                 op,
  input  logic [7:0]                    name_byte,
  output logic [hnpl_pkg::HASH_W-1:0]   name_hash
);
  import hnpl_pkg::*;

  logic [HASH_W-1:0] h;
  logic [HASH_W-1:0] p;
  logic [HASH_W-1:0] t;
  logic [HASH_W-1:0] opnd;
  logic [HASH_W-1:0] prod_byte;
  logic [HASH_W-1:0] prod_main;

  always_comb begin
    unique case (op)
      OP_BYTE_B: opnd = mix24(t);
      OP_FIN_A:  opnd = mix13(h);
      default:   opnd = h;
    endcase
  end

  assign prod_byte = mul_m({24'd0, name_byte});
  assign prod_main = mul_m(opnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      h <= '0;
    end else begin
      case (op)
        OP_BYTE_B: h <= p ^ prod_main;
        OP_FIN_B:  h <= '0;
        default:   h <= h;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_BYTE_A: begin
        t <= prod_byte;
        p <= prod_main;
      end
      OP_FIN_A: begin
        t <= prod_main;
      end
      OP_FIN_B: begin
        name_hash <= mix15(t);
      end
      default: begin
        t <= t;
      end
    endcase
  end

  a_byte_pair: assert property (@(posedge clk) disable iff (rst)
    (op == OP_BYTE_B) |-> ($past(op) == OP_BYTE_A))
    else $error("Second half of a byte step ran without the first half.");

endmodule

// File: rtl/hnpl_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed name permit list table
// Permit table memory with scan and write pointers, compare and result flags.
// ----------------------------------------------------------------------------
module hnpl_table (
  input  logic                        clk,
  input  logic                        rst,
  input  hnpl_pkg::op_t               op,
  input  logic [hnpl_pkg::HASH_W-1:0] name_hash,
  output logic                        permitted,
  output logic [1:0]                  status,
  output hnpl_pkg::tbl_flags_t        tflags
);
  import hnpl_pkg::*;

  logic [HASH_W-1:0]      mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;
  logic [IDX_W-1:0]       i;
  logic [CNT_W-1:0]       w;
  logic [HASH_W-1:0]      rd;
  logic                   we;
  logic [IDX_W-1:0]       wa;
  logic [HASH_W-1:0]      wd;
  logic                   i_last;
  logic                   w_end;

  function automatic logic [HASH_W-1:0] init_entry(input logic [IDX_W-1:0] a);
    if (int'(a) < NUM_BUILTIN) begin
      return BUILTIN_HASH[a[BI_W-1:0]];
    end
    return '0;
  endfunction

  assign i_last = (i == IDX_W'(TABLE_DEPTH - 1));
  assign w_end  = (w == CNT_W'(TABLE_DEPTH));

  assign tflags.scan_stop  = (rd == '0) || (rd == name_hash) || i_last;
  assign tflags.i_not_last = !i_last;
  assign tflags.w_end      = w_end;

  always_comb begin
    we = 1'b0;
    wa = i;
    wd = name_hash;
    case (op)
      OP_ADD_CMP: begin
        we = (rd == '0);
      end
      OP_REM_CMP: begin
        we = (rd != name_hash);
        wa = w[IDX_W-1:0];
        wd = rd;
      end
      OP_FILL: begin
        we = !w_end;
        wa = w[IDX_W-1:0];
        wd = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (op == OP_READ) begin
      rd <= valid[i] ? mem[i] : init_entry(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i         <= '0;
      w         <= '0;
      permitted <= 1'b0;
      status    <= ST_OK;
    end else begin
      case (op)
        OP_FIN_B: begin
          i         <= '0;
          w         <= '0;
          permitted <= 1'b0;
          status    <= ST_OK;
        end
        OP_CHK_CMP: begin
          i <= i + 1'b1;
          if (rd != '0 && rd == name_hash) begin
            permitted <= 1'b1;
          end
        end
        OP_SET_ZERO: begin
          if (name_hash == '0) begin
            status <= ST_ZERO;
          end
        end
        OP_ADD_CMP: begin
          i <= i + 1'b1;
          if (rd == '0) begin
            status <= ST_OK;
          end else if (rd == name_hash) begin
            status <= ST_DUP;
          end else if (i_last) begin
            status <= ST_FULL;
          end
        end
        OP_REM_CMP: begin
          i <= i + 1'b1;
          if (rd != name_hash) begin
            w <= w + 1'b1;
          end
        end
        OP_FILL: begin
          if (!w_end) begin
            w <= w + 1'b1;
          end
        end
        default: begin
          i <= i;
        end
      endcase
    end
  end

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (op == OP_REM_CMP) |-> (w <= CNT_W'(i)))
    else $error("Compaction write pointer ran ahead of the scan.");

endmodule

// File: rtl/hashed_name_permit_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed name permit list unit
// Hashes a name one byte per transfer and runs check, add or remove on the
// permit table when the name ends, under a microcoded sequencer.
// ----------------------------------------------------------------------------
// A byte that does not end the name keeps busy high for 1 cycle; the next byte
// is taken during the second of the two dependent multiply hash steps. A
// name-ending transfer finishes the hash (a zero byte skips the second step),
// then check or add scans to an empty slot, a match or the last entry (add
// ends on a zero hash), remove compacts and zero-fills, code 3 ends; done is
// registered. Results cannot be stalled. Reset restores the built-in table.
module hashed_name_permit_list_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd,
  input  logic [7:0]                  name_byte,
  input  logic                        is_last,
  output logic                        done,
  output logic [hnpl_pkg::HASH_W-1:0] name_hash,
  output logic                        permitted,
  output logic [1:0]                  status
);
  import hnpl_pkg::*;

  logic       byte_q;
  logic [7:0] name_byte_q;
  logic [1:0] cmd_q;
  logic       is_last_q;
  op_t        op;
  flags_t     flags;
  tbl_flags_t tflags;

  assign byte_q = start && !busy;

  always_ff @(posedge clk) begin
    if (byte_q) begin
      name_byte_q <= name_byte;
      cmd_q       <= cmd;
      is_last_q   <= is_last;
    end
  end

  always_comb begin
    flags.byte_zero  = (name_byte_q == 8'd0);
    flags.not_last   = !is_last_q;
    flags.cmd_check  = (cmd_q == CMD_CHECK);
    flags.cmd_add    = (cmd_q == CMD_ADD);
    flags.cmd_remove = (cmd_q == CMD_REMOVE);
    flags.hash_zero  = (name_hash == '0);
    flags.tbl        = tflags;
  end

  hnpl_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .done  (done),
    .op    (op)
  );

  hnpl_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .name_byte (name_byte_q),
    .name_hash (name_hash)
  );

  hnpl_table u_table (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .name_hash (name_hash),
    .permitted (permitted),
    .status    (status),
    .tflags    (tflags)
  );

endmodule
